// ===== rtl/imubd_pkg.sv =====
package imubd_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'hFA;
    localparam logic [7:0] HDR1_BYTE = 8'h01;
    localparam logic [7:0] HDR2_BYTE = 8'h29;
    localparam logic [7:0] HDR3_BYTE = 8'h05;

    localparam logic [6:0] FRAME_BYTES   = 7'd70;
    localparam logic [6:0] PAYLOAD_FIRST = 7'd4;
    localparam logic [6:0] PAYLOAD_END   = 7'd68;

    localparam logic [3:0] FIELD_TIME  = 4'd0;
    localparam logic [3:0] FIELD_GYRO_Y  = 4'd5;
    localparam logic [3:0] FIELD_GYRO_Z  = 4'd6;
    localparam logic [3:0] FIELD_ACCEL_Y = 4'd8;
    localparam logic [3:0] FIELD_ACCEL_Z = 4'd9;
    localparam logic [3:0] FIELD_LAST  = 4'd14;

    localparam logic [2:0] TIME_LAST_BYTE  = 3'd7;
    localparam logic [2:0] FLOAT_LAST_BYTE = 3'd3;

    localparam int unsigned BANK_ADDR_W = 6;
    localparam int unsigned MEM_ADDR_W  = BANK_ADDR_W + 1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_CAPT,
        BK_OUT
    } back_state_t;

    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } mem_wr_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } frame_tok_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]} ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage

// ===== rtl/imubd_front.sv =====
module imubd_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_rx_byte,
    input  logic                q_full,
    output imubd_pkg::frame_tok_t push_tok,
    output imubd_pkg::mem_wr_t  mem_wr
);
    import imubd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [15:0] crc_reg, crc_next;
    logic        bank_reg, bank_next;
    logic        accept;
    logic [15:0] crc_upd;
    logic [6:0]  cnt_inc;
    logic [6:0]  pos_off;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign crc_upd = crc_update(crc_reg, s_rx_byte);
    assign cnt_inc = cnt_reg + 7'd1;
    assign pos_off = cnt_reg - PAYLOAD_FIRST;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
            crc_reg   <= '0;
            bank_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
            bank_reg  <= bank_next;
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        crc_next       = crc_reg;
        bank_next      = bank_reg;
        push_tok.valid = 1'b0;
        push_tok.bank  = bank_reg;
        mem_wr.en      = 1'b0;
        mem_wr.addr    = {bank_reg, pos_off[BANK_ADDR_W-1:0]};
        mem_wr.data    = s_rx_byte;
        if (accept) begin
            unique case (phase_reg)
                PH_HDR1, PH_HDR2, PH_HDR3: begin
                    if ((phase_reg == PH_HDR1 && s_rx_byte == HDR1_BYTE) ||
                        (phase_reg == PH_HDR2 && s_rx_byte == HDR2_BYTE) ||
                        (phase_reg == PH_HDR3 && s_rx_byte == HDR3_BYTE)) begin
                        crc_next   = crc_upd;
                        cnt_next   = cnt_inc;
                        phase_next = (phase_reg == PH_HDR1) ? PH_HDR2 :
                                     (phase_reg == PH_HDR2) ? PH_HDR3 : PH_BODY;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY: begin
                    mem_wr.en = (cnt_reg >= PAYLOAD_FIRST) && (cnt_reg < PAYLOAD_END);
                    crc_next  = crc_upd;
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= FRAME_BYTES) begin
                        phase_next = PH_HUNT;
                        cnt_next   = '0;
                        if (crc_upd == 16'h0000) begin
                            push_tok.valid = 1'b1;
                            bank_next      = !bank_reg;
                        end
                    end
                end
                default: begin
                    if (s_rx_byte == SYNC_BYTE) begin
                        cnt_next   = 7'd1;
                        crc_next   = '0;
                        phase_next = PH_HDR1;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/imubd_queue.sv =====
module imubd_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  imubd_pkg::frame_tok_t push_tok,
    input  logic                  pop,
    output logic                  full,
    output imubd_pkg::frame_tok_t head_tok
);
    import imubd_pkg::*;

    logic [1:0] bank_q_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full           = (count_reg == 2'd2);
    assign head_tok.valid = (count_reg != 2'd0);
    assign head_tok.bank  = bank_q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_tok.valid) begin
            bank_q_reg[wr_ptr_reg] <= push_tok.bank;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push_tok.valid) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push_tok.valid} - {1'b0, pop};
        end
    end

endmodule

// ===== rtl/imubd_back.sv =====
module imubd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  enu_sign_flip,
    input  imubd_pkg::mem_wr_t    mem_wr,
    input  imubd_pkg::frame_tok_t head_tok,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_field_index,
    output logic [63:0]           m_field_value,
    output logic                  m_last_field
);
    import imubd_pkg::*;

    logic [7:0] mem [2**MEM_ADDR_W];

    back_state_t            state_reg, state_next;
    logic [3:0]             field_reg, field_next;
    logic [2:0]             byte_reg, byte_next;
    logic [BANK_ADDR_W-1:0] ptr_reg, ptr_next;
    logic [63:0]            value_reg, value_next;
    logic [7:0]             rd_data_reg;
    logic [2:0]             last_byte;
    logic                   flip;

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            mem[mem_wr.addr] <= mem_wr.data;
        end
        rd_data_reg <= mem[{head_tok.bank, ptr_reg}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            field_reg <= '0;
            byte_reg  <= '0;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            field_reg <= field_next;
            byte_reg  <= byte_next;
            ptr_reg   <= ptr_next;
        end
        value_reg <= value_next;
    end

    assign last_byte = (field_reg == FIELD_TIME) ? TIME_LAST_BYTE : FLOAT_LAST_BYTE;

    always_comb begin
        state_next = state_reg;
        field_next = field_reg;
        byte_next  = byte_reg;
        ptr_next   = ptr_reg;
        value_next = value_reg;
        pop        = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (head_tok.valid) begin
                    state_next = BK_FETCH;
                    field_next = '0;
                    byte_next  = '0;
                    ptr_next   = '0;
                    value_next = '0;
                end
            end
            BK_FETCH: begin
                state_next = BK_CAPT;
            end
            BK_CAPT: begin
                value_next = value_reg | ({56'h0, rd_data_reg} << {byte_reg, 3'b000});
                ptr_next   = ptr_reg + 1'b1;
                if (byte_reg == last_byte) begin
                    state_next = BK_OUT;
                end else begin
                    byte_next  = byte_reg + 3'd1;
                    state_next = BK_FETCH;
                end
            end
            BK_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (field_reg == FIELD_LAST) begin
                        pop        = 1'b1;
                        field_next = '0;
                        state_next = BK_IDLE;
                    end else begin
                        field_next = field_reg + 4'd1;
                        byte_next  = '0;
                        value_next = '0;
                        state_next = BK_FETCH;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign flip = enu_sign_flip &&
                  (field_reg == FIELD_GYRO_Y || field_reg == FIELD_GYRO_Z ||
                   field_reg == FIELD_ACCEL_Y || field_reg == FIELD_ACCEL_Z);

    assign m_field_index = field_reg;
    assign m_field_value = value_reg ^ {32'h0, flip, 31'h0};
    assign m_last_field  = (field_reg == FIELD_LAST);

`ifndef SYNTHESIS
    a_busy_has_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != BK_IDLE) |-> head_tok.valid)
        else $error("back end busy without a queued frame");

    a_field_range: assert property (@(posedge aclk) disable iff (!aresetn)
        field_reg <= FIELD_LAST)
        else $error("field index out of range");

    a_pop_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (m_valid && m_ready && m_last_field))
        else $error("frame released before its last field");

    a_float_upper_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && field_reg != FIELD_TIME) |-> (m_field_value[63:32] == 32'h0))
        else $error("float field has upper bits set");
`endif

endmodule

// ===== rtl/imu_binary_frame_deframer_crc_core.sv =====
// channel   ports                                    handshake
// input     s_rx_byte                                s_valid / s_ready
// result    m_field_index m_field_value m_last_field m_valid / m_ready
// config    psel penable pwrite paddr pwdata prdata  pready (always high)
//
// One byte word is taken per cycle; s_ready drops only while two good frames wait.
// A good frame gives 15 words, the time word from 8 stored bytes, each float from 4; the
// single read port fetches then captures each byte, and a word waits in BK_OUT for m_ready.
// Reset is synchronous, active low; it clears parse state and the frame queue.
// Front and back stall independently through a two-entry frame queue and banked store.
module imu_binary_frame_deframer_crc_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_field_index,
    output logic [63:0] m_field_value,
    output logic        m_last_field,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import imubd_pkg::*;

    logic       enu_sign_flip_reg;
    logic       q_full;
    logic       pop;
    frame_tok_t push_tok;
    frame_tok_t head_tok;
    mem_wr_t    mem_wr;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'h0 : {31'h0, enu_sign_flip_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enu_sign_flip_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            enu_sign_flip_reg <= pwdata[0];
        end
    end

    imubd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .push_tok  (push_tok),
        .mem_wr    (mem_wr)
    );

    imubd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_tok (push_tok),
        .pop      (pop),
        .full     (q_full),
        .head_tok (head_tok)
    );

    imubd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .enu_sign_flip (enu_sign_flip_reg),
        .mem_wr        (mem_wr),
        .head_tok      (head_tok),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_field_index (m_field_index),
        .m_field_value (m_field_value),
        .m_last_field  (m_last_field)
    );

endmodule
